@@ rtl/obbo_pkg.sv @@
// ----------------------------------------------------------------------------
// obbo_pkg
// Shared types and register indexes for the oriented box overlap test core.
// ----------------------------------------------------------------------------
package obbo_pkg;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_X   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_Y   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_Z   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_X     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_Y     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_Z     = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIENTATION = 3'd6;

   localparam logic [CSR_DATA_BITS-1:0] ORIENT_RESET = 64'd16384;

   // load enables of the two register stages inside one pipeline unit
   typedef struct packed {
      logic load_a;
      logic load_b;
   } stage_en_type;

endpackage

@@ rtl/obbo_rot.sv @@
// ----------------------------------------------------------------------------
// obbo_rot
// Quaternion to rotation matrix, two stages: component products, then
// matrix entries rounded half up and saturated to [-1, 1].
// ----------------------------------------------------------------------------
module obbo_rot #(
   parameter int QUAT_BITS = 16
) (
   input  logic                          clock,
   input  obbo_pkg::stage_en_type        en,
   input  logic signed [QUAT_BITS:0]     q_w,
   input  logic signed [QUAT_BITS:0]     q_x,
   input  logic signed [QUAT_BITS:0]     q_y,
   input  logic signed [QUAT_BITS:0]     q_z,
   output logic signed [QUAT_BITS-1:0]   m_out [3][3]
);

   localparam int F  = QUAT_BITS - 2;
   localparam int PW = 2 * QUAT_BITS + 2;
   localparam int EW = PW + 3;
   localparam logic signed [EW-1:0] ONE2  = EW'(1) <<< (2 * F);
   localparam logic signed [EW-1:0] ONE_E = EW'(1) <<< F;
   localparam logic signed [EW-1:0] HALF  = EW'(1) <<< (F - 1);

   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [EW-1:0] e [3][3];
   logic signed [QUAT_BITS-1:0] m_ff [3][3];

   function automatic logic signed [QUAT_BITS-1:0] rnd_sat(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] s;
      s = (v + HALF) >>> F;
      if (s > ONE_E) return QUAT_BITS'(ONE_E);
      if (s < -ONE_E) return QUAT_BITS'(-ONE_E);
      return QUAT_BITS'(s);
   endfunction

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         xx_ff <= q_x * q_x;
         yy_ff <= q_y * q_y;
         zz_ff <= q_z * q_z;
         xy_ff <= q_x * q_y;
         xz_ff <= q_x * q_z;
         yz_ff <= q_y * q_z;
         wx_ff <= q_w * q_x;
         wy_ff <= q_w * q_y;
         wz_ff <= q_w * q_z;
      end
   end

   always_comb begin
      e[0][0] = ONE2 - ((EW'(yy_ff) + EW'(zz_ff)) <<< 1);
      e[0][1] = (EW'(xy_ff) - EW'(wz_ff)) <<< 1;
      e[0][2] = (EW'(xz_ff) + EW'(wy_ff)) <<< 1;
      e[1][0] = (EW'(xy_ff) + EW'(wz_ff)) <<< 1;
      e[1][1] = ONE2 - ((EW'(xx_ff) + EW'(zz_ff)) <<< 1);
      e[1][2] = (EW'(yz_ff) - EW'(wx_ff)) <<< 1;
      e[2][0] = (EW'(xz_ff) - EW'(wy_ff)) <<< 1;
      e[2][1] = (EW'(yz_ff) + EW'(wx_ff)) <<< 1;
      e[2][2] = ONE2 - ((EW'(xx_ff) + EW'(yy_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (en.load_b) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               m_ff[i][j] <= rnd_sat(e[i][j]);
            end
         end
      end
   end

   assign m_out = m_ff;

endmodule

@@ rtl/obbo_rel.sv @@
// ----------------------------------------------------------------------------
// obbo_rel
// Relative rotation R = mA^T mB and center offset t in the frame of box A,
// two stages: products, then sums with rounding.
// ----------------------------------------------------------------------------
module obbo_rel #(
   parameter int COORD_BITS = 20,
   parameter int QUAT_BITS  = 16
) (
   input  logic                           clock,
   input  obbo_pkg::stage_en_type         en,
   input  logic signed [QUAT_BITS-1:0]    ma [3][3],
   input  logic signed [QUAT_BITS-1:0]    mb [3][3],
   input  logic signed [COORD_BITS:0]     d [3],
   output logic signed [QUAT_BITS-1:0]    r_out [3][3],
   output logic        [QUAT_BITS-2:0]    ar_out [3][3],
   output logic signed [COORD_BITS+2:0]   t_out [3]
);

   localparam int F   = QUAT_BITS - 2;
   localparam int PRW = 2 * QUAT_BITS;
   localparam int EW  = PRW + 2;
   localparam int PTW = QUAT_BITS + COORD_BITS + 1;
   localparam int TSW = PTW + 2;
   localparam logic signed [EW-1:0]  ONE_E  = EW'(1) <<< F;
   localparam logic signed [EW-1:0]  HALF   = EW'(1) <<< (F - 1);
   localparam logic signed [TSW-1:0] HALF_T = TSW'(1) <<< (F - 1);

   logic signed [PRW-1:0] pr_ff [3][3][3];
   logic signed [PTW-1:0] pt_ff [3][3];
   logic signed [EW-1:0]  rs [3][3];
   logic signed [TSW-1:0] ts [3];
   logic signed [QUAT_BITS-1:0]  r_ff [3][3];
   logic        [QUAT_BITS-2:0]  ar_ff [3][3];
   logic signed [COORD_BITS+2:0] t_ff [3];

   function automatic logic signed [QUAT_BITS-1:0] rnd_sat(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] s;
      s = (v + HALF) >>> F;
      if (s > ONE_E) return QUAT_BITS'(ONE_E);
      if (s < -ONE_E) return QUAT_BITS'(-ONE_E);
      return QUAT_BITS'(s);
   endfunction

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               pt_ff[i][k] <= ma[k][i] * d[k];
               for (int j = 0; j < 3; j++) begin
                  pr_ff[i][j][k] <= ma[k][i] * mb[k][j];
               end
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ts[i] = (TSW'(pt_ff[i][0]) + TSW'(pt_ff[i][1]) + TSW'(pt_ff[i][2]) + HALF_T) >>> F;
         for (int j = 0; j < 3; j++) begin
            rs[i][j] = EW'(pr_ff[i][j][0]) + EW'(pr_ff[i][j][1]) + EW'(pr_ff[i][j][2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.load_b) begin
         for (int i = 0; i < 3; i++) begin
            t_ff[i] <= ts[i][COORD_BITS+2:0];
            for (int j = 0; j < 3; j++) begin
               r_ff[i][j] <= rnd_sat(rs[i][j]);
               if (rnd_sat(rs[i][j]) < 0) begin
                  ar_ff[i][j] <= (QUAT_BITS-1)'(-rnd_sat(rs[i][j]));
               end else begin
                  ar_ff[i][j] <= (QUAT_BITS-1)'(rnd_sat(rs[i][j]));
               end
            end
         end
      end
   end

   assign r_out  = r_ff;
   assign ar_out = ar_ff;
   assign t_out  = t_ff;

endmodule

@@ rtl/obbo_sep.sv @@
// ----------------------------------------------------------------------------
// obbo_sep
// Separating axis tests over the 15 axes, two stages: projection products,
// then sums and compares.
// ----------------------------------------------------------------------------
module obbo_sep #(
   parameter int COORD_BITS = 20,
   parameter int QUAT_BITS  = 16
) (
   input  logic                           clock,
   input  obbo_pkg::stage_en_type         en,
   input  logic signed [COORD_BITS+2:0]   t [3],
   input  logic signed [QUAT_BITS-1:0]    r [3][3],
   input  logic        [QUAT_BITS-2:0]    ar [3][3],
   input  logic        [COORD_BITS-2:0]   ha [3],
   input  logic        [COORD_BITS-2:0]   hb [3],
   output logic                           overlap
);

   localparam int F   = QUAT_BITS - 2;
   localparam int TW  = COORD_BITS + 3;
   localparam int TRW = TW + QUAT_BITS;
   localparam int HRW = COORD_BITS + QUAT_BITS - 2;
   localparam int SW  = COORD_BITS + QUAT_BITS + 6;

   logic signed [TRW-1:0]        tr_ff [3][3][3];
   logic        [HRW-1:0]        har_ff [3][3][3];
   logic        [HRW-1:0]        hbr_ff [3][3][3];
   logic signed [TW-1:0]         t_ff [3];
   logic        [COORD_BITS-2:0] ha_ff [3];
   logic        [COORD_BITS-2:0] hb_ff [3];
   logic                         sep;
   logic                         overlap_ff;

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         for (int a = 0; a < 3; a++) begin
            t_ff[a]  <= t[a];
            ha_ff[a] <= ha[a];
            hb_ff[a] <= hb[a];
            for (int b = 0; b < 3; b++) begin
               for (int j = 0; j < 3; j++) begin
                  tr_ff[a][b][j]  <= t[a] * r[b][j];
                  har_ff[a][b][j] <= ha[a] * ar[b][j];
                  hbr_ff[j][a][b] <= hb[a] * ar[j][b];
               end
            end
         end
      end
   end

   always_comb begin
      logic signed [SW-1:0] p, pa, ra, rb;
      int i1, i2, j1, j2;
      sep = 1'b0;
      // face axes of A
      for (int i = 0; i < 3; i++) begin
         p = SW'(t_ff[i]);
         pa = (p < 0) ? -p : p;
         ra = $signed(SW'(ha_ff[i])) <<< F;
         rb = $signed(SW'(hbr_ff[i][0][0])) + $signed(SW'(hbr_ff[i][1][1]))
            + $signed(SW'(hbr_ff[i][2][2]));
         if ((pa <<< F) > ra + rb) sep = 1'b1;
      end
      // face axes of B
      for (int j = 0; j < 3; j++) begin
         p = SW'(tr_ff[0][0][j]) + SW'(tr_ff[1][1][j]) + SW'(tr_ff[2][2][j]);
         pa = (p < 0) ? -p : p;
         ra = $signed(SW'(har_ff[0][0][j])) + $signed(SW'(har_ff[1][1][j]))
            + $signed(SW'(har_ff[2][2][j]));
         rb = $signed(SW'(hb_ff[j])) <<< F;
         if (pa > ra + rb) sep = 1'b1;
      end
      // edge axes
      for (int i = 0; i < 3; i++) begin
         i1 = (i == 2) ? 0 : i + 1;
         i2 = (i == 0) ? 2 : i - 1;
         for (int j = 0; j < 3; j++) begin
            j1 = (j == 2) ? 0 : j + 1;
            j2 = (j == 0) ? 2 : j - 1;
            p = SW'(tr_ff[i2][i1][j]) - SW'(tr_ff[i1][i2][j]);
            pa = (p < 0) ? -p : p;
            ra = $signed(SW'(har_ff[i1][i2][j])) + $signed(SW'(har_ff[i2][i1][j]));
            rb = $signed(SW'(hbr_ff[i][j1][j2])) + $signed(SW'(hbr_ff[i][j2][j1]));
            if (pa > ra + rb) sep = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.load_b) begin
         overlap_ff <= !sep;
      end
   end

   assign overlap = overlap_ff;

endmodule

@@ rtl/obb_obb_overlap_test_core.sv @@
// ----------------------------------------------------------------------------
// obb_obb_overlap_test_core
// Throughput: one beat per cycle while rsp_stall is low; six register stages,
// each holding its beat under stall, with bubbles squeezed out.
// Reset clears the stage valid bits and loads the register defaults
// (identity orientation, zero center and half extents).
// ----------------------------------------------------------------------------
module obb_obb_overlap_test_core #(
   parameter int COORD_BITS = 20,
   parameter int QUAT_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_BITS-1:0]           req_center_x,
   input  logic signed [COORD_BITS-1:0]           req_center_y,
   input  logic signed [COORD_BITS-1:0]           req_center_z,
   input  logic        [COORD_BITS-2:0]           req_half_x,
   input  logic        [COORD_BITS-2:0]           req_half_y,
   input  logic        [COORD_BITS-2:0]           req_half_z,
   input  logic signed [QUAT_BITS-1:0]            req_quat_w,
   input  logic signed [QUAT_BITS-1:0]            req_quat_x,
   input  logic signed [QUAT_BITS-1:0]            req_quat_y,
   input  logic signed [QUAT_BITS-1:0]            req_quat_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_boxes_overlap,
   input  logic                                   csr_wr_en,
   input  logic [obbo_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [obbo_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int F      = QUAT_BITS - 2;
   localparam int QW     = QUAT_BITS + 1;
   localparam int STAGES = 6;

   logic signed [COORD_BITS-1:0] qc_ff [3];
   logic        [COORD_BITS-2:0] qh_ff [3];
   logic        [obbo_pkg::CSR_DATA_BITS-1:0] orient_ff;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] en;

   logic signed [QW-1:0] qb [4];
   logic signed [COORD_BITS:0] d1_ff [3];
   logic signed [COORD_BITS:0] d2_ff [3];
   logic [COORD_BITS-2:0] ha_ff [4][3];
   logic [COORD_BITS-2:0] hb_ff [4][3];

   logic signed [QUAT_BITS-1:0] ma [3][3];
   logic signed [QUAT_BITS-1:0] mb [3][3];
   logic signed [QUAT_BITS-1:0] r [3][3];
   logic        [QUAT_BITS-2:0] ar [3][3];
   logic signed [COORD_BITS+2:0] t [3];

   obbo_pkg::stage_en_type en_rot, en_rel, en_sep;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            qc_ff[k] <= '0;
            qh_ff[k] <= '0;
         end
         orient_ff <= obbo_pkg::ORIENT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            obbo_pkg::CSR_CENTER_X:    qc_ff[0] <= csr_wdata[COORD_BITS-1:0];
            obbo_pkg::CSR_CENTER_Y:    qc_ff[1] <= csr_wdata[COORD_BITS-1:0];
            obbo_pkg::CSR_CENTER_Z:    qc_ff[2] <= csr_wdata[COORD_BITS-1:0];
            obbo_pkg::CSR_HALF_X:      qh_ff[0] <= csr_wdata[COORD_BITS-2:0];
            obbo_pkg::CSR_HALF_Y:      qh_ff[1] <= csr_wdata[COORD_BITS-2:0];
            obbo_pkg::CSR_HALF_Z:      qh_ff[2] <= csr_wdata[COORD_BITS-2:0];
            obbo_pkg::CSR_ORIENTATION: orient_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage enables: a stage loads when empty or when its beat moves on
   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || !rsp_stall;
      for (int s = STAGES - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int s = 1; s < STAGES; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[STAGES-1];

   assign en_rot = '{load_a: en[0], load_b: en[1]};
   assign en_rel = '{load_a: en[2], load_b: en[3]};
   assign en_sep = '{load_a: en[4], load_b: en[5]};

   // query quaternion lanes rescaled to F fraction bits
   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic signed [15:0] lane;
      assign lane = orient_ff[16*k +: 16];
      if (F >= 14) begin : g_up
         assign qb[k] = QW'(lane) <<< (F - 14);
      end else begin : g_dn
         logic signed [16:0] lr;
         assign lr = (17'(lane) + (17'sd1 <<< (13 - F))) >>> (14 - F);
         assign qb[k] = QW'(lr);
      end
   end

   // side payload: center offset and half extents
   always_ff @(posedge clock) begin
      if (en[0]) begin
         d1_ff[0] <= (COORD_BITS+1)'(qc_ff[0]) - (COORD_BITS+1)'(req_center_x);
         d1_ff[1] <= (COORD_BITS+1)'(qc_ff[1]) - (COORD_BITS+1)'(req_center_y);
         d1_ff[2] <= (COORD_BITS+1)'(qc_ff[2]) - (COORD_BITS+1)'(req_center_z);
         ha_ff[0][0] <= req_half_x;
         ha_ff[0][1] <= req_half_y;
         ha_ff[0][2] <= req_half_z;
         hb_ff[0] <= qh_ff;
      end
      if (en[1]) begin
         d2_ff <= d1_ff;
      end
      for (int s = 1; s < 4; s++) begin
         if (en[s]) begin
            ha_ff[s] <= ha_ff[s-1];
            hb_ff[s] <= hb_ff[s-1];
         end
      end
   end

   obbo_rot #(.QUAT_BITS(QUAT_BITS)) u_rot_a (
      .clock (clock),
      .en    (en_rot),
      .q_w   (QW'(req_quat_w)),
      .q_x   (QW'(req_quat_x)),
      .q_y   (QW'(req_quat_y)),
      .q_z   (QW'(req_quat_z)),
      .m_out (ma)
   );

   obbo_rot #(.QUAT_BITS(QUAT_BITS)) u_rot_b (
      .clock (clock),
      .en    (en_rot),
      .q_w   (qb[0]),
      .q_x   (qb[1]),
      .q_y   (qb[2]),
      .q_z   (qb[3]),
      .m_out (mb)
   );

   obbo_rel #(.COORD_BITS(COORD_BITS), .QUAT_BITS(QUAT_BITS)) u_rel (
      .clock  (clock),
      .en     (en_rel),
      .ma     (ma),
      .mb     (mb),
      .d      (d2_ff),
      .r_out  (r),
      .ar_out (ar),
      .t_out  (t)
   );

   obbo_sep #(.COORD_BITS(COORD_BITS), .QUAT_BITS(QUAT_BITS)) u_sep (
      .clock   (clock),
      .en      (en_sep),
      .t       (t),
      .r       (r),
      .ar      (ar),
      .ha      (ha_ff[3]),
      .hb      (hb_ff[3]),
      .overlap (rsp_boxes_overlap)
   );

   // pipeline can only refuse input when the output beat is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req stalled while pipeline has room");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[0])
      else $error("accepted beat lost at first stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule
